[rtl/pidc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Integral accumulator width and the digit width of the shared multiplier.
  localparam int INTEG_WIDTH = 48;
  localparam int DIG_WIDTH   = 16;
  localparam int RES_WIDTH   = 64;

  typedef logic [2:0] cfg_addr_t;

  localparam cfg_addr_t CFG_GAIN_P        = 3'd0;
  localparam cfg_addr_t CFG_GAIN_I        = 3'd1;
  localparam cfg_addr_t CFG_GAIN_D        = 3'd2;
  localparam cfg_addr_t CFG_SAMPLE_PERIOD = 3'd3;
  localparam cfg_addr_t CFG_DRIVE_MIN     = 3'd4;
  localparam cfg_addr_t CFG_DRIVE_MAX     = 3'd5;

  localparam logic signed [RES_WIDTH-1:0] RES_MAX = {1'b0, {(RES_WIDTH-1){1'b1}}};
  localparam logic signed [RES_WIDTH-1:0] RES_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

  // Saturating add on the 64-bit result range.
  function automatic logic signed [RES_WIDTH-1:0] sat_add64(
    input logic signed [RES_WIDTH-1:0] a,
    input logic signed [RES_WIDTH-1:0] b
  );
    logic signed [RES_WIDTH-1:0] s;
    s = a + b;
    if (!a[RES_WIDTH-1] && !b[RES_WIDTH-1] && s[RES_WIDTH-1]) begin
      s = RES_MAX;
    end else if (a[RES_WIDTH-1] && b[RES_WIDTH-1] && !s[RES_WIDTH-1]) begin
      s = RES_MIN;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/pid_position_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        request    in_valid / in_ready     in_target, in_measured
// out       result     out_valid / out_ready   out_drive, out_clamped, out_zero_period
// cfg       write      cfg_we                  cfg_addr, cfg_wdata
//
// A result is written once the derivative product is summed and clamped, and the next
// request is taken in the cycle after it is written; the serial divider for the
// derivative produces one quotient bit a cycle. A zero sample period skips the
// divider.
// The four products share one multiplier that takes a 16-bit digit per cycle.
// Reset clears the integral, the last error and the registers to their defaults.
// A new request is taken while a result waits; the finished result then holds
// until out_ready frees the output register.

module pid_position_controller_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]  in_target,
  input  wire logic signed [DATA_WIDTH-1:0]  in_measured,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]       out_drive,
  output logic                               out_clamped,
  output logic                               out_zero_period,
  input  wire logic                          cfg_we,
  input  wire pidc_pkg::cfg_addr_t           cfg_addr,
  input  wire logic [DATA_WIDTH-1:0]         cfg_wdata
);

  localparam int W  = DATA_WIDTH;
  localparam int IW = pidc_pkg::INTEG_WIDTH;
  localparam int RW = pidc_pkg::RES_WIDTH;
  localparam int XW = (W + 1 + FRAC_BITS > RW) ? W + 1 + FRAC_BITS : RW;

  localparam logic signed [W-1:0]  D_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  D_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};

  localparam logic signed [W-1:0] RST_GAIN_P = W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [W-1:0] RST_GAIN_I = W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [W-1:0] RST_GAIN_D = W'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
  localparam logic [W-2:0]        RST_PERIOD = (W-1)'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
  localparam logic signed [W-1:0] RST_MIN    = W'(-(64'sd10 <<< FRAC_BITS));
  localparam logic signed [W-1:0] RST_MAX    = W'(64'sd10 <<< FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_DIFF, S_NUM, S_INTEG, S_PSTART, S_PWAIT,
    S_ISTART, S_IWAIT, S_DWAIT, S_DMUL, S_CLAMP
  } state_t;

  state_t               state_r, state_nxt;

  logic signed [W-1:0]  gain_p_r, gain_p_nxt;
  logic signed [W-1:0]  gain_i_r, gain_i_nxt;
  logic signed [W-1:0]  gain_d_r, gain_d_nxt;
  logic [W-2:0]         period_r, period_nxt;
  logic signed [W-1:0]  drive_min_r, drive_min_nxt;
  logic signed [W-1:0]  drive_max_r, drive_max_nxt;

  logic signed [W-1:0]  target_r, target_nxt;
  logic signed [W-1:0]  measured_r, measured_nxt;
  logic signed [W-1:0]  err_r, err_nxt;
  logic signed [W:0]    diff_r, diff_nxt;
  logic signed [W-1:0]  last_err_r, last_err_nxt;
  logic signed [IW-1:0] integ_r, integ_nxt;
  logic signed [RW-1:0] sum_r, sum_nxt;
  logic                 zp_r, zp_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [W-1:0]  out_drive_r, out_drive_nxt;
  logic                 out_clamped_r, out_clamped_nxt;
  logic                 out_zp_r, out_zp_nxt;

  logic                 mul_start;
  logic signed [IW-1:0] mul_a;
  logic signed [W-1:0]  mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic signed [RW-1:0] mul_res;

  logic                 div_start;
  logic signed [RW-1:0] div_num;
  logic                 div_busy;
  logic signed [W-1:0]  div_quot;

  logic signed [W:0]    err_wide;
  logic signed [XW-1:0] num_wide;
  logic [XW-RW:0]       num_top;
  logic signed [RW-1:0] isum;
  logic [RW-IW:0]       isum_top;
  logic signed [RW-1:0] drive_min_x;
  logic signed [RW-1:0] drive_max_x;
  logic                 out_free;

  pidc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pidc_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (period_r),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign err_wide = {target_r[W-1], target_r} - {measured_r[W-1], measured_r};

  // Change in error scaled up by the fraction bits, held to the 64-bit range.
  assign num_wide = XW'(diff_r) <<< FRAC_BITS;
  assign num_top  = num_wide[XW-1:RW-1];
  assign div_num  = (&num_top || ~|num_top) ? num_wide[RW-1:0]
                  : (num_wide[XW-1] ? pidc_pkg::RES_MIN : pidc_pkg::RES_MAX);

  assign isum     = pidc_pkg::sat_add64(mul_res, RW'(integ_r));
  assign isum_top = isum[RW-1:IW-1];

  assign drive_min_x = RW'(drive_min_r);
  assign drive_max_x = RW'(drive_max_r);
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = IW'(err_r);
    mul_b     = gain_p_r;
    div_start = 1'b0;
    case (state_r)
      S_DIFF: begin
        mul_start = 1'b1;
        mul_b     = {1'b0, period_r};
      end
      S_PSTART: mul_start = 1'b1;
      S_ISTART: begin
        mul_start = 1'b1;
        mul_a     = integ_r;
        mul_b     = gain_i_r;
      end
      S_DWAIT: begin
        mul_start = !div_busy;
        mul_a     = zp_r ? '0 : IW'(div_quot);
        mul_b     = gain_d_r;
      end
      S_NUM: div_start = (period_r != '0);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    gain_p_nxt      = gain_p_r;
    gain_i_nxt      = gain_i_r;
    gain_d_nxt      = gain_d_r;
    period_nxt      = period_r;
    drive_min_nxt   = drive_min_r;
    drive_max_nxt   = drive_max_r;
    target_nxt      = target_r;
    measured_nxt    = measured_r;
    err_nxt         = err_r;
    diff_nxt        = diff_r;
    last_err_nxt    = last_err_r;
    integ_nxt       = integ_r;
    sum_nxt         = sum_r;
    zp_nxt          = zp_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_drive_nxt   = out_drive_r;
    out_clamped_nxt = out_clamped_r;
    out_zp_nxt      = out_zp_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        pidc_pkg::CFG_GAIN_P:        gain_p_nxt    = cfg_wdata;
        pidc_pkg::CFG_GAIN_I:        gain_i_nxt    = cfg_wdata;
        pidc_pkg::CFG_GAIN_D:        gain_d_nxt    = cfg_wdata;
        pidc_pkg::CFG_SAMPLE_PERIOD: period_nxt    = cfg_wdata[W-2:0];
        pidc_pkg::CFG_DRIVE_MIN:     drive_min_nxt = cfg_wdata;
        pidc_pkg::CFG_DRIVE_MAX:     drive_max_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          target_nxt   = in_target;
          measured_nxt = in_measured;
          state_nxt    = S_ERR;
        end
      end
      S_ERR: begin
        if (err_wide[W] != err_wide[W-1]) begin
          err_nxt = err_wide[W] ? D_MIN : D_MAX;
        end else begin
          err_nxt = err_wide[W-1:0];
        end
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        diff_nxt     = {err_r[W-1], err_r} - {last_err_r[W-1], last_err_r};
        last_err_nxt = err_r;
        state_nxt    = S_NUM;
      end
      S_NUM: begin
        zp_nxt    = (period_r == '0);
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        if (mul_done) begin
          integ_nxt = (&isum_top || ~|isum_top) ? isum[IW-1:0]
                    : (isum[RW-1] ? I_MIN : I_MAX);
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: state_nxt = S_PWAIT;
      S_PWAIT: begin
        if (mul_done) begin
          sum_nxt   = mul_res;
          state_nxt = S_ISTART;
        end
      end
      S_ISTART: state_nxt = S_IWAIT;
      S_IWAIT: begin
        if (mul_done) begin
          sum_nxt   = pidc_pkg::sat_add64(sum_r, mul_res);
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!div_busy) begin
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: begin
        if (mul_done) begin
          sum_nxt   = pidc_pkg::sat_add64(sum_r, mul_res);
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          if (sum_r < drive_min_x) begin
            out_drive_nxt   = drive_min_r;
            out_clamped_nxt = 1'b1;
          end else if (sum_r > drive_max_x) begin
            out_drive_nxt   = drive_max_r;
            out_clamped_nxt = 1'b1;
          end else begin
            out_drive_nxt   = sum_r[W-1:0];
            out_clamped_nxt = 1'b0;
          end
          out_zp_nxt    = zp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    target_r      <= target_nxt;
    measured_r    <= measured_nxt;
    err_r         <= err_nxt;
    diff_r        <= diff_nxt;
    sum_r         <= sum_nxt;
    zp_r          <= zp_nxt;
    out_drive_r   <= out_drive_nxt;
    out_clamped_r <= out_clamped_nxt;
    out_zp_r      <= out_zp_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_p_r    <= RST_GAIN_P;
      gain_i_r    <= RST_GAIN_I;
      gain_d_r    <= RST_GAIN_D;
      period_r    <= RST_PERIOD;
      drive_min_r <= RST_MIN;
      drive_max_r <= RST_MAX;
      last_err_r  <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      period_r    <= period_nxt;
      drive_min_r <= drive_min_nxt;
      drive_max_r <= drive_max_nxt;
      last_err_r  <= last_err_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_drive       = out_drive_r;
  assign out_clamped     = out_clamped_r;
  assign out_zero_period = out_zp_r;

  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!div_busy && period_r != '0))
    else $error("divider started while busy or with zero period");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CLAMP))
    else $error("result appeared outside the clamp step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_drive_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[rtl/pidc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidc_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start_i,
  input  wire logic signed [pidc_pkg::INTEG_WIDTH-1:0] a_i,
  input  wire logic signed [DATA_WIDTH-1:0]           b_i,
  output logic                                        busy_o,
  output logic                                        done_o,
  output logic signed [pidc_pkg::RES_WIDTH-1:0]       res_o
);

  localparam int AW  = pidc_pkg::INTEG_WIDTH;
  localparam int DW  = pidc_pkg::DIG_WIDTH;
  localparam int RW  = pidc_pkg::RES_WIDTH;
  localparam int ND  = (DATA_WIDTH + DW - 1) / DW;
  localparam int BW  = ND * DW;
  localparam int PW  = AW + BW;
  localparam int SW  = (PW > RW + FRAC_BITS) ? PW : RW + FRAC_BITS;
  localparam int CW  = $clog2(ND + 1);
  localparam int PPW = AW + DW + 1;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_SAT} mstate_t;

  mstate_t               state_r, state_nxt;
  logic signed [AW-1:0]  a_r, a_nxt;
  logic [BW-1:0]         b_r, b_nxt;
  logic                  first_r, first_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;
  logic signed [RW-1:0]  res_r, res_nxt;
  logic                  done_r, done_nxt;

  logic signed [DW:0]    dig;
  logic signed [PPW-1:0] pp;
  logic signed [SW-1:0]  ext;
  logic signed [SW-1:0]  shv;
  logic [SW-RW:0]        top_bits;
  logic signed [RW-1:0]  sat_val;

  // Digits are taken most significant first; only the top digit carries the sign.
  assign dig = {first_r ? b_r[BW-1] : 1'b0, b_r[BW-1 -: DW]};
  assign pp  = PPW'(a_r) * PPW'(dig);

  assign ext      = SW'(acc_r);
  assign shv      = ext >>> FRAC_BITS;
  assign top_bits = shv[SW-1:RW-1];
  assign sat_val  = (&top_bits || ~|top_bits) ? shv[RW-1:0]
                  : (ext[SW-1] ? pidc_pkg::RES_MIN : pidc_pkg::RES_MAX);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (start_i) begin
          a_nxt     = a_i;
          b_nxt     = BW'(b_i);
          first_nxt = 1'b1;
          cnt_nxt   = CW'(ND);
          acc_nxt   = '0;
          state_nxt = M_RUN;
        end
      end
      M_RUN: begin
        acc_nxt   = (acc_r <<< DW) + PW'(pp);
        b_nxt     = b_r << DW;
        first_nxt = 1'b0;
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = M_SAT;
        end
      end
      M_SAT: begin
        res_nxt   = sat_val;
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy_o = (state_r != M_IDLE);
  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

`default_nettype wire

[rtl/pidc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidc_div #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start_i,
  input  wire logic signed [pidc_pkg::RES_WIDTH-1:0] num_i,
  input  wire logic [DATA_WIDTH-2:0]                den_i,
  output logic                                      busy_o,
  output logic signed [DATA_WIDTH-1:0]              quot_o
);

  localparam int W    = DATA_WIDTH;
  localparam int RW   = pidc_pkg::RES_WIDTH;
  localparam int HW   = RW - W;
  localparam int CMPW = (HW > W - 1) ? HW : W - 1;
  localparam int CNTW = $clog2(W + 1);

  localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {D_IDLE, D_ABS, D_CHK, D_RUN, D_SAT} dstate_t;

  dstate_t               state_r, state_nxt;
  logic signed [RW-1:0]  num_r, num_nxt;
  logic [W-2:0]          den_r, den_nxt;
  logic                  neg_r, neg_nxt;
  logic [RW-1:0]         mag_r, mag_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [W-2:0]          rem_r, rem_nxt;
  logic [W-1:0]          lo_r, lo_nxt;
  logic [W-1:0]          q_r, q_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic signed [W-1:0]   quot_r, quot_nxt;

  logic [CMPW-1:0]       hi_x;
  logic [CMPW-1:0]       den_x;
  logic [W-1:0]          shifted;
  logic [W:0]            trial;
  logic                  ge;

  assign hi_x    = CMPW'(mag_r[RW-1:W]);
  assign den_x   = CMPW'(den_r);
  assign shifted = {rem_r, lo_r[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = !trial[W];

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    quot_nxt  = quot_r;
    unique case (state_r)
      D_IDLE: begin
        if (start_i) begin
          num_nxt   = num_i;
          den_nxt   = den_i;
          state_nxt = D_ABS;
        end
      end
      D_ABS: begin
        neg_nxt   = num_r[RW-1];
        mag_nxt   = num_r[RW-1] ? RW'(-num_r) : RW'(num_r);
        state_nxt = D_CHK;
      end
      D_CHK: begin
        // Quotient needs at most W bits; anything larger saturates anyway.
        ovf_nxt   = (hi_x >= den_x);
        rem_nxt   = hi_x[W-2:0];
        lo_nxt    = mag_r[W-1:0];
        q_nxt     = '0;
        cnt_nxt   = CNTW'(W);
        state_nxt = D_RUN;
      end
      D_RUN: begin
        rem_nxt = ge ? trial[W-2:0] : shifted[W-2:0];
        lo_nxt  = lo_r << 1;
        q_nxt   = {q_r[W-2:0], ge};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          state_nxt = D_SAT;
        end
      end
      D_SAT: begin
        if (ovf_r) begin
          quot_nxt = neg_r ? Q_MIN : Q_MAX;
        end else if (neg_r) begin
          quot_nxt = (q_r[W-1] && |q_r[W-2:0]) ? Q_MIN : W'(-q_r);
        end else begin
          quot_nxt = q_r[W-1] ? Q_MAX : q_r;
        end
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    ovf_r  <= ovf_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy_o = (state_r != D_IDLE);
  assign quot_o = quot_r;

endmodule

`default_nettype wire

[test/pid_position_controller_top_tb.sv]
`timescale 1ns / 1ps

module pid_position_controller_top_tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int SETTLE_CYCLES = 60;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 180;

  localparam logic signed [DW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic                 clamped;
    logic                 zero_period;
  } drive_result_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    pidc_pkg::cfg_addr_t  addr;
    logic [DW-1:0]        value;
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] measured;
    logic                 typed;
    drive_result_t        want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] in_target = '0;
  logic signed [DW-1:0] in_measured = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_drive;
  logic                 out_clamped;
  logic                 out_zero_period;
  logic                 cfg_we = 1'b0;
  pidc_pkg::cfg_addr_t  cfg_addr = pidc_pkg::CFG_GAIN_P;
  logic [DW-1:0]        cfg_wdata = '0;

  // Register copies and controller state, reset values.
  longint kp = 65536;
  longint ki = 32768;
  longint kd = 6554;
  longint period = 6554;
  longint lo_limit = -655360;
  longint hi_limit = 655360;
  longint integ_acc = 0;
  longint last_err_model = 0;

  drive_result_t pending_drives[$];
  stim_row_t     script[$];
  int            mismatch_count = 0;
  logic          steady = 1'b0;
  int            stall_left = 0;

  pid_position_controller_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_target      (in_target),
    .in_measured    (in_measured),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive      (out_drive),
    .out_clamped    (out_clamped),
    .out_zero_period(out_zero_period),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clip_to(wide_t x, int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return longint'(hi);
    if (x < lo) return longint'(lo);
    return longint'(x);
  endfunction

  // Exact product, floor shift, saturate to 64 bits.
  function automatic longint scaled_product(longint a, longint b);
    wide_t p;
    p = (wide_t'(a) * wide_t'(b)) >>> FB;
    return clip_to(p, 64);
  endfunction

  function automatic void set_register(pidc_pkg::cfg_addr_t a, logic [DW-1:0] v);
    case (a)
      pidc_pkg::CFG_GAIN_P:        kp = $signed(v);
      pidc_pkg::CFG_GAIN_I:        ki = $signed(v);
      pidc_pkg::CFG_GAIN_D:        kd = $signed(v);
      pidc_pkg::CFG_SAMPLE_PERIOD: period = longint'(v[DW-2:0]);
      pidc_pkg::CFG_DRIVE_MIN:     lo_limit = $signed(v);
      pidc_pkg::CFG_DRIVE_MAX:     hi_limit = $signed(v);
      default: ;
    endcase
  endfunction

  function automatic drive_result_t compute_drive(logic signed [DW-1:0] tgt,
                                                  logic signed [DW-1:0] meas);
    longint err;
    longint diff;
    longint deriv;
    longint total;
    drive_result_t r;
    err = clip_to(wide_t'(tgt) - wide_t'(meas), DW);
    integ_acc = clip_to(clip_to(wide_t'(integ_acc) + wide_t'(scaled_product(err, period)), 64),
                        pidc_pkg::INTEG_WIDTH);
    deriv = 0;
    r.zero_period = (period == 0);
    if (period != 0) begin
      diff = err - last_err_model;
      deriv = clip_to(wide_t'((diff <<< FB) / period), DW);
    end
    total = clip_to(wide_t'(scaled_product(kp, err)) + wide_t'(scaled_product(ki, integ_acc)),
                    64);
    total = clip_to(wide_t'(total) + wide_t'(scaled_product(kd, deriv)), 64);
    // Lower limit wins when the limits are inverted.
    r.clamped = 1'b1;
    if (total < lo_limit) begin
      r.drive = lo_limit[DW-1:0];
    end else if (total > hi_limit) begin
      r.drive = hi_limit[DW-1:0];
    end else begin
      r.drive = total[DW-1:0];
      r.clamped = 1'b0;
    end
    last_err_model = err;
    return r;
  endfunction

  function automatic void add_write(pidc_pkg::cfg_addr_t a, logic [DW-1:0] v);
    stim_row_t row;
    row = '{ROW_WRITE, a, v, '0, '0, 1'b0, '{'0, 1'b0, 1'b0}};
    script.push_back(row);
  endfunction

  function automatic void add_request(logic signed [DW-1:0] t, logic signed [DW-1:0] m);
    stim_row_t row;
    row = '{ROW_REQUEST, pidc_pkg::CFG_GAIN_P, '0, t, m, 1'b0, '{'0, 1'b0, 1'b0}};
    script.push_back(row);
  endfunction

  function automatic void add_checked(logic signed [DW-1:0] t, logic signed [DW-1:0] m,
                                      logic signed [DW-1:0] d, logic cl, logic zp);
    stim_row_t row;
    row = '{ROW_REQUEST, pidc_pkg::CFG_GAIN_P, '0, t, m, 1'b1, '{d, cl, zp}};
    script.push_back(row);
  endfunction

  task automatic write_register(pidc_pkg::cfg_addr_t a, logic [DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(posedge clk);
    set_register(a, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(logic signed [DW-1:0] tgt, logic signed [DW-1:0] meas,
                              logic typed, drive_result_t want);
    int gap;
    drive_result_t got;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(7) == 0) gap = $urandom_range(60, 1);
      else while ($urandom_range(99) < 34) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target <= tgt;
    in_measured <= meas;
    do @(posedge clk); while (!in_ready);
    got = compute_drive(tgt, meas);
    pending_drives.push_back(typed ? want : got);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_gain();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4, 5: return $urandom_range(262144, 0) - 32'd131072;
      6, 7, 8: return $urandom_range(2097152, 0) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_period();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'd1;
      3, 4, 5, 6: return $urandom_range(65536, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_limit();
    case ($urandom_range(5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom;
      default: return $urandom_range(2097152, 0) - 32'd1048576;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // Result side: check accepted results, stall at random.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t unexpected result: drive %0d clamped %0b zero_period %0b",
                 $time, out_drive, out_clamped, out_zero_period);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive) begin
          $display("%0t drive expected %0d actual %0d", $time, want.drive, out_drive);
          mismatch_count++;
        end
        if (out_clamped !== want.clamped) begin
          $display("%0t clamped expected %0b actual %0b", $time, want.clamped, out_clamped);
          mismatch_count++;
        end
        if (out_zero_period !== want.zero_period) begin
          $display("%0t zero_period expected %0b actual %0b", $time, want.zero_period,
                   out_zero_period);
          mismatch_count++;
        end
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 34) begin
      out_ready <= 1'b0;
      if ($urandom_range(49) == 0) stall_left <= $urandom_range(40, 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #12_000_000;
    $display("pid_position_controller_top: mismatch");
    $finish;
  end

  initial begin
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] swap;
    logic signed [DW-1:0] tgt;
    logic signed [DW-1:0] meas;
    drive_result_t none;

    none = '{'0, 1'b0, 1'b0};

    // Defaults after reset, then the error extremes.
    add_checked(0, 0, 0, 1'b0, 1'b0);
    add_checked(Q_MAX, Q_MIN, 655360, 1'b1, 1'b0);
    add_checked(Q_MIN, Q_MAX, -655360, 1'b1, 1'b0);
    add_request(32'sh0001_2345, 32'sh0000_2000);
    add_request(-70000, 3);
    add_request(0, 0);
    // Zero period: derivative drops out, integral holds.
    add_write(pidc_pkg::CFG_SAMPLE_PERIOD, '0);
    add_request(1000, -5000);
    add_write(pidc_pkg::CFG_GAIN_P, '0);
    add_write(pidc_pkg::CFG_GAIN_I, '0);
    add_write(pidc_pkg::CFG_GAIN_D, '0);
    add_checked(Q_MAX, Q_MIN, 0, 1'b0, 1'b1);
    // Extreme gains and period: drive the integral and products into saturation.
    add_write(pidc_pkg::CFG_GAIN_P, Q_MAX);
    add_write(pidc_pkg::CFG_GAIN_I, Q_MIN);
    add_write(pidc_pkg::CFG_GAIN_D, Q_MAX);
    add_write(pidc_pkg::CFG_SAMPLE_PERIOD, 32'h7FFF_FFFF);
    add_write(pidc_pkg::CFG_DRIVE_MIN, Q_MIN);
    add_write(pidc_pkg::CFG_DRIVE_MAX, Q_MAX);
    repeat (3) add_request(Q_MAX, Q_MIN);
    repeat (3) add_request(Q_MIN, Q_MAX);
    add_request(-1, 0);
    add_request(0, 1);
    // Proportional only: a sum on a limit passes unclamped.
    add_write(pidc_pkg::CFG_GAIN_P, 32'd65536);
    add_write(pidc_pkg::CFG_GAIN_I, '0);
    add_write(pidc_pkg::CFG_GAIN_D, '0);
    add_write(pidc_pkg::CFG_SAMPLE_PERIOD, 32'd6554);
    add_write(pidc_pkg::CFG_DRIVE_MIN, -32'sd655360);
    add_write(pidc_pkg::CFG_DRIVE_MAX, 32'sd655360);
    add_checked(655360, 0, 655360, 1'b0, 1'b0);
    add_checked(-655360, 0, -655360, 1'b0, 1'b0);
    add_checked(655361, 0, 655360, 1'b1, 1'b0);
    add_checked(0, 655361, -655360, 1'b1, 1'b0);
    // Inverted limits.
    add_write(pidc_pkg::CFG_DRIVE_MIN, 32'sd100);
    add_write(pidc_pkg::CFG_DRIVE_MAX, -32'sd100);
    add_request(5, 5);
    add_request(32'sh0004_0000, 0);
    add_request(0, 32'sh0004_0000);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i-1].kind != ROW_WRITE) wait_idle();
        write_register(script[i].addr, script[i].value);
      end else begin
        send_request(script[i].target, script[i].measured, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      steady = (ph == 2);
      lo = pick_limit();
      hi = pick_limit();
      // Keep most limit pairs ordered; leave the rest inverted.
      if ($urandom_range(5) != 0 && lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      if (ph == 0) begin
        write_register(pidc_pkg::CFG_GAIN_P, 32'd65536);
        write_register(pidc_pkg::CFG_GAIN_I, 32'd32768);
        write_register(pidc_pkg::CFG_GAIN_D, 32'd6554);
        write_register(pidc_pkg::CFG_SAMPLE_PERIOD, 32'd6554);
        write_register(pidc_pkg::CFG_DRIVE_MIN, -32'sd655360);
        write_register(pidc_pkg::CFG_DRIVE_MAX, 32'sd655360);
      end else begin
        write_register(pidc_pkg::CFG_GAIN_P, pick_gain());
        write_register(pidc_pkg::CFG_GAIN_I, pick_gain());
        write_register(pidc_pkg::CFG_GAIN_D, pick_gain());
        write_register(pidc_pkg::CFG_SAMPLE_PERIOD, pick_period());
        write_register(pidc_pkg::CFG_DRIVE_MIN, lo);
        write_register(pidc_pkg::CFG_DRIVE_MAX, hi);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: begin
            tgt = $urandom;
            meas = $urandom;
          end
          1: begin
            tgt = pick_extreme();
            meas = pick_extreme();
          end
          default: begin
            // Tracking loop: measurement close to the setpoint.
            tgt = $urandom_range(32'h1F_FFFF, 0) - 32'h10_0000;
            meas = tgt + ($urandom_range(131071, 0) - 32'd65536);
          end
        endcase
        send_request(tgt, meas, 1'b0, none);
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatch_count == 0) begin
      $display("pid_position_controller_top: match");
    end else begin
      $display("pid_position_controller_top: mismatch");
    end
    $finish;
  end

endmodule
